// ----- rtl/core/ptt_seq_pkg.sv -----
// Shared widths, register indexes and payload constants for the PTT relay sequencer.
// No dependencies; compiled first.
package ptt_seq_pkg;

  // Battery converter sample width (8 to 16).
  localparam int SAMPLE_BITS   = 10;

  localparam int GAP_BITS      = 16;
  localparam int LOW_CODE_BITS = 10;
  localparam int STAGE_COUNT   = 4;
  localparam int STAGE_IDX_BITS = $clog2(STAGE_COUNT);

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  // Width at which sample and threshold are compared.
  localparam int CMP_BITS = (SAMPLE_BITS > LOW_CODE_BITS) ? SAMPLE_BITS : LOW_CODE_BITS;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_UP_GAP    = 2'd0,
    REG_DOWN_GAP  = 2'd1,
    REG_LOW_CODE  = 2'd2,
    REG_PTT_LEVEL = 2'd3
  } cfg_reg_t;

  // Reset values of the registers.
  localparam logic [GAP_BITS-1:0]      UP_GAP_RESET    = 16'd15;
  localparam logic [GAP_BITS-1:0]      DOWN_GAP_RESET  = 16'd15;
  localparam logic [LOW_CODE_BITS-1:0] LOW_CODE_RESET  = 10'd751;
  localparam logic                     PTT_LEVEL_RESET = 1'b0;

  typedef logic [STAGE_COUNT-1:0] stage_vec_t;

endpackage

// ----- rtl/core/ptt_seq_if.sv -----
// Valid/ready channel interfaces for the sequencer: tick item in, result item out.
// Depends on ptt_seq_pkg.
interface ptt_seq_sample_if;
  import ptt_seq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   ptt_level;
  logic [SAMPLE_BITS-1:0] battery_sample;

  modport source (output valid, output ptt_level, output battery_sample, input ready);
  modport sink   (input valid, input ptt_level, input battery_sample, output ready);
endinterface

interface ptt_seq_result_if;
  import ptt_seq_pkg::*;

  logic       valid;
  logic       ready;
  stage_vec_t stage_outputs;
  logic       alarm;
  logic       busy_res;

  modport source (output valid, output stage_outputs, output alarm, output busy_res,
                  input ready);
  modport sink   (input valid, input stage_outputs, input alarm, input busy_res,
                  output ready);
endinterface

// ----- rtl/core/ptt_relay_sequencer_top.sv -----
// Top level of the four-stage PTT transmit/receive relay sequencer.
// Depends on ptt_seq_pkg and the channel interfaces in ptt_seq_if.sv.
//
// Usage:
//   sample_ch carries one item per timer tick: the sampled PTT pin level and a
//   raw battery code. result_ch returns exactly one item per tick: the stage
//   outputs, the alarm and a busy flag, all as they stand after that tick.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes the up gap,
//   down gap, battery low threshold and PTT active level; write only when idle.
// Result register and throughput:
//   An accepted tick's result is written straight into the output register.
//   One tick per cycle sustained while the receiver takes each result: the
//   state update is a single short pass of logic (one 16-bit increment and
//   compare) between the state registers and the output register.
// Reset:
//   Synchronous, active high. Alarm set, all stages off, startup wait until
//   PTT reads released; registers return to their reset values; no result held.
// Stalls:
//   A held result keeps its value; a new tick is still taken in the same cycle
//   the held one leaves, so the output register never blocks a full-rate flow.
module ptt_relay_sequencer_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [ptt_seq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ptt_seq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  ptt_seq_sample_if.sink                          sample_ch,
  ptt_seq_result_if.source                        result_ch
);
  import ptt_seq_pkg::*;

  typedef enum logic [1:0] {
    MODE_STARTUP,
    MODE_IDLE,
    MODE_UP,
    MODE_DOWN
  } mode_t;

  // Configuration registers
  logic [GAP_BITS-1:0]      up_gap;
  logic [GAP_BITS-1:0]      down_gap;
  logic [LOW_CODE_BITS-1:0] low_code;
  logic                     ptt_active_level;

  // Sequencer state
  mode_t                     mode, mode_next;
  logic [STAGE_IDX_BITS-1:0] stage_index, stage_index_next;
  logic [GAP_BITS-1:0]       gap_counter, gap_counter_next;
  logic                      ptt_engaged_last, ptt_engaged_last_next;
  stage_vec_t                stage_bits, stage_bits_next;
  logic                      alarm_flag, alarm_flag_next;

  // Output register
  logic       out_valid;
  stage_vec_t out_stages;
  logic       out_alarm;
  logic       out_busy;

  logic                      accept;
  logic                      engaged;
  logic                      battery_low;
  logic [GAP_BITS-1:0]       count_inc;
  logic [GAP_BITS-1:0]       gap_sel;
  logic                      gap_done;
  logic [STAGE_IDX_BITS-1:0] idx_up, idx_down;

  // Output register frees up in the same cycle its item is taken.
  assign sample_ch.ready = !out_valid || result_ch.ready;
  assign accept          = sample_ch.valid && sample_ch.ready;

  assign engaged     = (sample_ch.ptt_level == ptt_active_level);
  assign battery_low = CMP_BITS'(sample_ch.battery_sample) < CMP_BITS'(low_code);

  // Gap timing: a gap of zero acts as one since the incremented count is never below it.
  assign count_inc = gap_counter + GAP_BITS'(1);
  assign gap_sel   = (mode == MODE_UP) ? up_gap : down_gap;
  assign gap_done  = (count_inc >= gap_sel);
  assign idx_up    = stage_index + STAGE_IDX_BITS'(1);
  assign idx_down  = stage_index - STAGE_IDX_BITS'(1);

  always_comb begin
    mode_next             = mode;
    stage_index_next      = stage_index;
    gap_counter_next      = gap_counter;
    ptt_engaged_last_next = ptt_engaged_last;
    stage_bits_next       = stage_bits;
    alarm_flag_next       = alarm_flag;

    case (mode)
      MODE_STARTUP: begin
        // Leave startup only once PTT is seen released; no event on that tick.
        if (!engaged) begin
          alarm_flag_next       = 1'b0;
          ptt_engaged_last_next = 1'b0;
          mode_next             = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        if (battery_low || (!engaged && ptt_engaged_last)) begin
          // Low battery wins and leaves the stored PTT state alone.
          if (battery_low) begin
            alarm_flag_next = 1'b1;
          end else begin
            ptt_engaged_last_next = 1'b0;
          end
          stage_bits_next                  = stage_bits;
          stage_bits_next[STAGE_COUNT-1]   = 1'b0;
          stage_index_next                 = STAGE_IDX_BITS'(STAGE_COUNT - 1);
          gap_counter_next                 = '0;
          mode_next                        = MODE_DOWN;
        end else if (engaged && !ptt_engaged_last) begin
          ptt_engaged_last_next = 1'b1;
          stage_bits_next       = stage_bits | stage_vec_t'(1);
          stage_index_next      = '0;
          gap_counter_next      = '0;
          mode_next             = MODE_UP;
        end
      end
      MODE_UP: begin
        gap_counter_next = count_inc;
        if (gap_done) begin
          gap_counter_next = '0;
          stage_index_next = idx_up;
          stage_bits_next  = stage_bits | (stage_vec_t'(1) << idx_up);
          if (idx_up == STAGE_IDX_BITS'(STAGE_COUNT - 1)) begin
            mode_next = MODE_IDLE;
          end
        end
      end
      MODE_DOWN: begin
        gap_counter_next = count_inc;
        if (gap_done) begin
          gap_counter_next = '0;
          stage_index_next = idx_down;
          stage_bits_next  = stage_bits & ~(stage_vec_t'(1) << idx_down);
          if (idx_down == '0) begin
            mode_next = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_next = MODE_STARTUP;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      up_gap           <= UP_GAP_RESET;
      down_gap         <= DOWN_GAP_RESET;
      low_code         <= LOW_CODE_RESET;
      ptt_active_level <= PTT_LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_UP_GAP:    up_gap           <= cfg_data[GAP_BITS-1:0];
        REG_DOWN_GAP:  down_gap         <= cfg_data[GAP_BITS-1:0];
        REG_LOW_CODE:  low_code         <= cfg_data[LOW_CODE_BITS-1:0];
        REG_PTT_LEVEL: ptt_active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_STARTUP;
      stage_index      <= '0;
      gap_counter      <= '0;
      ptt_engaged_last <= 1'b0;
      stage_bits       <= '0;
      alarm_flag       <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        mode             <= mode_next;
        stage_index      <= stage_index_next;
        gap_counter      <= gap_counter_next;
        ptt_engaged_last <= ptt_engaged_last_next;
        stage_bits       <= stage_bits_next;
        alarm_flag       <= alarm_flag_next;
        out_valid        <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      out_stages <= stage_bits_next;
      out_alarm  <= alarm_flag_next;
      out_busy   <= (mode_next != MODE_IDLE);
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.stage_outputs = out_stages;
  assign result_ch.alarm         = out_alarm;
  assign result_ch.busy_res      = out_busy;

endmodule

// ----- rtl/core/ptt_seq_check.sv -----
// Port-level checker for ptt_relay_sequencer_top, attached by the bind below.
// Depends on ptt_seq_pkg.
module ptt_seq_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ptt_seq_pkg::STAGE_COUNT-1:0] out_stages,
  input logic                           out_alarm,
  input logic                           out_busy
);
  import ptt_seq_pkg::*;

  // Each accepted tick yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // An empty output register never holds off the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_stages)
      && $stable(out_alarm) && $stable(out_busy))
    else $error("stalled result changed");

  // Between ramps the stages are either all on or all off.
  a_idle_stages: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_busy |-> (out_stages == '0) || (out_stages == '1))
    else $error("partial stage pattern while idle");

endmodule

bind ptt_relay_sequencer_top ptt_seq_check u_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_ch.valid),
  .in_ready   (sample_ch.ready),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .out_stages (result_ch.stage_outputs),
  .out_alarm  (result_ch.alarm),
  .out_busy   (result_ch.busy_res)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ptt_relay_sequencer_top: timer tick items in, stage/alarm items out.
// Depends on ptt_seq_pkg and the channel interfaces in ptt_seq_if.sv.
module testbench;
  import ptt_seq_pkg::*;

  // Longest stretch with no item moving on either channel: the receiver hold-off
  // plus the longest sender gap plus a register write, with a wide margin.
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SAMPLE_MAX      = 2**SAMPLE_BITS - 1;

  // Sequencer modes as the expected-state tracker sees them.
  typedef enum logic [1:0] {
    SEQ_STARTUP,
    SEQ_IDLE,
    SEQ_RAMP_UP,
    SEQ_RAMP_DOWN
  } seq_mode_t;

  typedef struct packed {
    stage_vec_t stages;
    logic       alarm;
    logic       busy;
  } stage_status_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  ptt_seq_sample_if sample_ch ();
  ptt_seq_result_if result_ch ();

  ptt_relay_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // 4 ns period, first rising edge at 2 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the registers, as the block holds them after masking.
  logic [GAP_BITS-1:0]      up_gap       = UP_GAP_RESET;
  logic [GAP_BITS-1:0]      down_gap     = DOWN_GAP_RESET;
  logic [LOW_CODE_BITS-1:0] low_code     = LOW_CODE_RESET;
  logic                     active_level = PTT_LEVEL_RESET;

  // Expected sequencer state, reset values.
  seq_mode_t                 pred_mode     = SEQ_STARTUP;
  logic [STAGE_IDX_BITS-1:0] stage_idx     = '0;
  logic [GAP_BITS-1:0]       gap_count     = '0;
  logic                      engaged_last  = 1'b0;
  stage_vec_t                stage_bits    = '0;
  logic                      alarm_latched = 1'b1;

  // One entry per accepted tick, oldest first.
  stage_status_t status_due[$];

  int mismatch_count    = 0;
  int quiet_cycles      = 0;
  int stall_left        = 0;
  bit src_idle_on       = 1'b0;
  bit sink_stalls_on    = 1'b0;
  bit sink_hold_pending = 1'b0;

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Battery codes: mostly healthy for the current threshold, some low, some anywhere.
  function automatic logic [SAMPLE_BITS-1:0] pick_battery();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0 && low_code != 0) return SAMPLE_BITS'($urandom_range(0, low_code - 1));
    if (r < 3) return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    return SAMPLE_BITS'($urandom_range(low_code, SAMPLE_MAX));
  endfunction

  function automatic void start_ramp_down();
    stage_bits[STAGE_COUNT-1] = 1'b0;
    stage_idx                 = STAGE_IDX_BITS'(STAGE_COUNT - 1);
    gap_count                 = '0;
    pred_mode                 = SEQ_RAMP_DOWN;
  endfunction

  // Moves the expected state on by one tick and queues what the block should show.
  function automatic void advance_sequencer(logic lvl, logic [SAMPLE_BITS-1:0] smp);
    logic engaged;
    engaged = (lvl == active_level);
    case (pred_mode)
      SEQ_STARTUP: begin
        // Release clears the alarm; no event is looked at on this tick.
        if (!engaged) begin
          alarm_latched = 1'b0;
          engaged_last  = 1'b0;
          pred_mode     = SEQ_IDLE;
        end
      end
      SEQ_IDLE: begin
        if (smp < low_code) begin
          // Low battery wins over PTT; stored PTT state left alone.
          alarm_latched = 1'b1;
          start_ramp_down();
        end else if (engaged != engaged_last) begin
          engaged_last = engaged;
          if (engaged) begin
            stage_bits[0] = 1'b1;
            stage_idx     = '0;
            gap_count     = '0;
            pred_mode     = SEQ_RAMP_UP;
          end else begin
            start_ramp_down();
          end
        end
      end
      SEQ_RAMP_UP: begin
        gap_count = gap_count + 1'b1;
        if (gap_count >= up_gap) begin
          gap_count             = '0;
          stage_idx             = stage_idx + 1'b1;
          stage_bits[stage_idx] = 1'b1;
          if (stage_idx == STAGE_COUNT - 1) pred_mode = SEQ_IDLE;
        end
      end
      default: begin
        gap_count = gap_count + 1'b1;
        if (gap_count >= down_gap) begin
          gap_count             = '0;
          stage_idx             = stage_idx - 1'b1;
          stage_bits[stage_idx] = 1'b0;
          if (stage_idx == 0) pred_mode = SEQ_IDLE;
        end
      end
    endcase
    status_due.push_back('{stages: stage_bits, alarm: alarm_latched,
                           busy: (pred_mode != SEQ_IDLE)});
  endfunction

  // Offers one tick item and returns at the edge that takes it. Called at a rising
  // edge; valid is left high so back-to-back items need no second assignment.
  task automatic send_tick(logic lvl, logic [SAMPLE_BITS-1:0] smp);
    int idle;
    idle = src_idle_on ? pick_gap() : 0;
    if (idle > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.ptt_level      <= lvl;
    sample_ch.battery_sample <= smp;
    do @(posedge clk); while (!sample_ch.ready);
    advance_sequencer(lvl, smp);
  endtask

  // Inputs are ignored while a ramp runs: fill with arbitrary items until it ends.
  task automatic run_until_idle();
    while (pred_mode == SEQ_RAMP_UP || pred_mode == SEQ_RAMP_DOWN)
      send_tick(1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
  endtask

  // Sender stops and waits for every outstanding result.
  task automatic wait_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_UP_GAP:    up_gap       = val[GAP_BITS-1:0];
      REG_DOWN_GAP:  down_gap     = val[GAP_BITS-1:0];
      REG_LOW_CODE:  low_code     = val[LOW_CODE_BITS-1:0];
      REG_PTT_LEVEL: active_level = val[0];
      default: ;
    endcase
  endtask

  // Registers change only with no ramp running and nothing in flight.
  task automatic set_registers(logic [CFG_DATA_BITS-1:0] up, logic [CFG_DATA_BITS-1:0] down,
                               logic [CFG_DATA_BITS-1:0] low, logic [CFG_DATA_BITS-1:0] lvl);
    run_until_idle();
    wait_results();
    write_reg(REG_UP_GAP, up);
    write_reg(REG_DOWN_GAP, down);
    write_reg(REG_LOW_CODE, low);
    write_reg(REG_PTT_LEVEL, lvl);
    cfg_we <= 1'b0;
  endtask

  // Reset values: active low PTT, threshold 751, gaps of 15.
  task automatic test_startup();
    send_tick(1'b0, 10'd0);     // engaged and flat battery: still waiting, alarm high
    send_tick(1'b0, 10'd1023);
    send_tick(1'b1, 10'd751);   // release seen: alarm clears, idle
    send_tick(1'b1, 10'd751);   // nothing changed
    send_tick(1'b0, 10'd1023);  // engage: stage one at once, then 15-tick gaps
    run_until_idle();
    wait_results();
  endtask

  task automatic test_directed();
    // Zero up gap must act as a gap of one.
    set_registers(16'd0, 16'd2, 16'd751, 16'd0);
    send_tick(1'b1, 10'd751);   // release at the threshold (not low): ramp down
    run_until_idle();
    send_tick(1'b0, 10'd1023);  // engage: ramp up
    run_until_idle();
    send_tick(1'b0, 10'd1023);  // no change, stays idle
    send_tick(1'b1, 10'd750);   // one below threshold beats the release
    run_until_idle();
    send_tick(1'b1, 10'd0);     // still low: ramp down restarts from all off
    run_until_idle();
    send_tick(1'b1, 10'd1023);  // stored state was kept, so the release shows now
    run_until_idle();
    send_tick(1'b0, 10'd1023);  // engage while the alarm stays latched
    run_until_idle();
    // Active high PTT, threshold zero; upper data bits must be dropped.
    set_registers(16'd1, 16'd1, 16'hFC00, 16'hFFFF);
    send_tick(1'b1, 10'd0);     // engaged, matches stored state; code 0 is not low
    send_tick(1'b0, 10'd0);     // released: ramp down
    run_until_idle();
    // Highest threshold: only full scale counts as healthy.
    set_registers(16'd1, 16'd1, 16'd1023, 16'd1);
    send_tick(1'b1, 10'd1023);  // engage
    run_until_idle();
    send_tick(1'b1, 10'd1022);  // low
    run_until_idle();
  endtask

  // Long gaps: one full ramp each way at the full item rate.
  task automatic test_widest_gaps();
    src_idle_on    = 1'b0;
    sink_stalls_on = 1'b0;
    set_registers(16'd24, 16'd24, 16'd0, 16'd0);
    send_tick(1'b1, 10'd512);   // release: ramp down
    run_until_idle();
    send_tick(1'b0, 10'd512);   // engage: ramp up
    run_until_idle();
  endtask

  // Receiver holds off while the sender keeps offering, so the block must stall
  // its input; then the sender waits for every result before going on.
  task automatic test_backpressure();
    src_idle_on    = 1'b0;
    sink_stalls_on = 1'b0;
    set_registers(16'd2, 16'd2, 16'd0, 16'd0);
    sink_hold_pending = 1'b1;
    for (int n = 0; n < 30; n++)
      send_tick(n[3], SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
    wait_results();
  endtask

  // Several register settings, each with about sixteen items that meet an idle
  // sequencer; PTT mostly held and toggled, with some noise items.
  task automatic test_random_settings();
    logic held_level;
    int   live;
    for (int setting = 0; setting < 6; setting++) begin
      case (setting)
        0: begin
          src_idle_on    = 1'b0;
          sink_stalls_on = 1'b0;
          set_registers(16'd1, 16'd1, 16'd0, 16'd0);
        end
        1: begin
          src_idle_on    = 1'b1;
          sink_stalls_on = 1'b1;
          set_registers(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), 16'd751, 16'd1);
        end
        2: begin
          src_idle_on    = 1'b1;
          sink_stalls_on = 1'b0;
          set_registers(16'd3, 16'd2, 16'd1023, 16'd0);
        end
        default: begin
          src_idle_on    = (setting != 3);
          sink_stalls_on = 1'b1;
          set_registers(16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                        16'($urandom), 16'($urandom));
        end
      endcase
      held_level = 1'($urandom_range(0, 1));
      live       = 0;
      while (live < 16) begin
        if (pred_mode == SEQ_IDLE) begin
          live++;
          if ($urandom_range(0, 2) == 0) held_level = ~held_level;
        end
        if ($urandom_range(0, 9) == 0)
          send_tick(1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
        else
          send_tick(held_level, pick_battery());
      end
    end
  endtask

  // Receiver: ready held low for a requested hold-off or a random stall, else high.
  always @(posedge clk) begin
    if (sink_hold_pending) begin
      sink_hold_pending = 1'b0;
      stall_left        = HOLD_OFF_CYCLES;
    end
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
      if (sink_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Each result item against the oldest expectation, field by field.
  always @(posedge clk) begin
    stage_status_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (status_due.size() == 0) begin
        flag_mismatch("result with nothing due", 32'(result_ch.stage_outputs), 0);
      end else begin
        want = status_due.pop_front();
        if (result_ch.stage_outputs !== want.stages)
          flag_mismatch("stage_outputs", 32'(result_ch.stage_outputs), 32'(want.stages));
        if (result_ch.alarm !== want.alarm)
          flag_mismatch("alarm", 32'(result_ch.alarm), 32'(want.alarm));
        if (result_ch.busy_res !== want.busy)
          flag_mismatch("busy_res", 32'(result_ch.busy_res), 32'(want.busy));
      end
    end
  end

  // Watchdog: too long with no item moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                      <= 1'b1;
    cfg_we                   <= 1'b0;
    cfg_index                <= REG_UP_GAP;
    cfg_data                 <= '0;
    sample_ch.valid          <= 1'b0;
    sample_ch.ptt_level      <= 1'b0;
    sample_ch.battery_sample <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_startup();
    test_directed();
    test_widest_gaps();
    test_backpressure();
    test_random_settings();

    // Let the last result out, then check that nothing stray is left.
    wait_results();
    repeat (4) @(posedge clk);
    if (status_due.size() != 0)
      flag_mismatch("results never delivered", status_due.size(), 0);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
